FILE: hw/rtl/bplru_pkg.sv
// package for the buffer pool lru tag manager: types and constants
`timescale 1ns / 1ps
`default_nettype none
package bplru_pkg;
	localparam int ENTRIES = 16;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	typedef enum logic [2:0] {
		OP_LOOKUP = 3'd0,
		OP_TOUCH = 3'd1,
		OP_DIRTY = 3'd2,
		OP_PIN = 3'd3,
		OP_UNPIN = 3'd4,
		OP_QUERY = 3'd5,
		OP_FREE = 3'd6,
		OP_WBACK = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] file_id;
		logic [19:0] block_offset;
		logic [3:0]  entry_index;
	} in_word_t;

	typedef struct packed {
		logic [3:0]  result_index;
		logic        hit;
		logic        full_res;
		logic        dirty_flag;
		logic [15:0] flush_mask;
		logic        fetch_needed;
	} out_word_t;

	// cell command broadcast to every cell
	typedef struct packed {
		logic        apply;     // one cycle strobe: commit per-cell op
		op_t         op;
		logic [15:0] file_id;
		logic [19:0] block_offset;
		logic        sel_valid; // addressed index in range, or a victim found on a lookup miss
		logic [3:0]  sel;       // addressed / victim entry
		logic        alloc;     // lookup miss with a victim
		logic        flush;     // lookup miss: clean all
		logic [31:0] now;
	} cell_cmd_t;

	// word handed down the chain during the scan
	typedef struct packed {
		logic [31:0] stamp;
		logic        dirty;
		logic        pinned;
		logic        match;
	} chain_t;
endpackage
`default_nettype wire

FILE: hw/rtl/bplru_cell.sv
// one buffer entry cell: tag, flags, stamp, and a rotating scan shift stage
`timescale 1ns / 1ps
`default_nettype none
module bplru_cell
	import bplru_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire  [3:0] index,
	input  cell_cmd_t  cmd,
	input  wire        load,
	input  wire        shift,
	input  chain_t     prev,
	output chain_t     cur,
	output logic       dirty
);
	logic        valid_q, dirty_q, pinned_q;
	logic [15:0] file_q;
	logic [19:0] block_q;
	logic [31:0] stamp_q;
	chain_t      scan_q;
	logic        me;

	assign me = cmd.sel_valid && (cmd.sel == index);
	assign cur = scan_q;
	assign dirty = dirty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
			pinned_q <= 1'b0;
			file_q <= '0;
			block_q <= '0;
			stamp_q <= '0;
		end else if (cmd.apply) begin
			case (cmd.op)
				OP_LOOKUP: begin
					if (cmd.flush) dirty_q <= 1'b0;
					if (cmd.alloc && me) begin
						valid_q <= 1'b1;
						file_q <= cmd.file_id;
						block_q <= cmd.block_offset;
						dirty_q <= 1'b0;
						stamp_q <= cmd.now;
					end
				end
				OP_TOUCH: if (me) stamp_q <= cmd.now;
				OP_DIRTY: if (me) dirty_q <= 1'b1;
				OP_PIN:   if (me) pinned_q <= 1'b1;
				OP_UNPIN: if (me) pinned_q <= 1'b0;
				OP_FREE: begin
					if (valid_q && file_q == cmd.file_id) begin
						valid_q <= 1'b0;
						file_q <= '0;
						block_q <= '0;
						dirty_q <= 1'b0;
						pinned_q <= 1'b0;
					end
				end
				OP_WBACK: if (me) dirty_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			scan_q.stamp <= stamp_q;
			scan_q.dirty <= dirty_q;
			scan_q.pinned <= pinned_q;
			scan_q.match <= valid_q && file_q == cmd.file_id
				&& block_q == cmd.block_offset;
		end else if (shift) begin
			scan_q <= prev;
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/buffer_pool_lru_tag_manager.sv
// top level of the buffer pool lru tag manager
// usage: raise start for one cycle with word when busy is low; the word is
// taken at that edge and busy rises. the cell chain rotates one entry per
// cycle past the scan head; each item passes a load step, a scan of every
// entry and a commit step before the done strobe. result is valid for
// exactly one cycle with done high, and busy falls in that same cycle,
// so a new start may follow at once.
// the receiver cannot stall; results must be taken when done is high.
// the scan head keeps the first tag match, the least-stamped unpinned entry
// (lowest index on ties) and the dirty mask; the commit cycle broadcasts the
// chosen operation to every cell.
// every opcode advances the saturating item counter that stamps entries.
// reset (arst_n low) clears all entries, the counter and the controller;
// no item is accepted while arst_n is low.
// entry indices at or beyond ENTRIES give an all-zero result and no change.
`timescale 1ns / 1ps
`default_nettype none
module buffer_pool_lru_tag_manager
	import bplru_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       start,
	input  in_word_t  word,
	output logic      busy,
	output logic      done,
	output out_word_t result
);
	state_t      state_q, state_d;
	in_word_t    req_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0] now_q;
	logic        hit_q, vic_ok_q;
	logic [3:0]  hit_idx_q, vic_idx_q;
	logic [31:0] vic_stamp_q;
	logic [15:0] dmask_q;
	out_word_t   res_q;
	logic        done_q;
	cell_cmd_t   cmd;
	chain_t      chain [ENTRIES];
	logic [ENTRIES-1:0] dbits;
	logic        load, shift, accept, idx_ok;
	chain_t      head;
	logic [3:0]  pos;

	assign accept = start && !busy;
	assign load = accept;
	assign shift = (state_q == ST_SCAN);
	assign head = chain[0];
	assign pos = 4'(cnt_q);
	assign idx_ok = 32'(req_q.entry_index) < ENTRIES;

	always_comb begin
		unique case (state_q)
			ST_IDLE: state_d = accept ? ST_SCAN : ST_IDLE;
			ST_SCAN: state_d = (32'(cnt_q) == ENTRIES - 1) ? ST_DONE : ST_SCAN;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
		done = done_q;
		result = res_q;
	end

	always_comb begin
		cmd = '0;
		cmd.op = op_t'(req_q.opcode);
		// tag compare at load sees the incoming word
		cmd.file_id = accept ? word.file_id : req_q.file_id;
		cmd.block_offset = accept ? word.block_offset : req_q.block_offset;
		cmd.now = now_q;
		cmd.apply = (state_q == ST_DONE);
		if (op_t'(req_q.opcode) == OP_LOOKUP) begin
			cmd.flush = !hit_q;
			cmd.alloc = !hit_q && vic_ok_q;
			cmd.sel_valid = !hit_q && vic_ok_q;
			cmd.sel = vic_idx_q;
		end else begin
			cmd.sel_valid = idx_ok;
			cmd.sel = req_q.entry_index;
		end
	end

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			bplru_cell u_cell (
				.clk(clk), .arst_n(arst_n), .index(4'(g)), .cmd(cmd), .load(load),
				.shift(shift), .prev(chain[(g + 1) % ENTRIES]),
				.cur(chain[g]), .dirty(dbits[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			now_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == ST_DONE);
			if (accept) begin
				cnt_q <= '0;
				if (now_q != 32'hFFFF_FFFF) now_q <= now_q + 32'd1;
			end else if (shift) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= word;
			hit_q <= 1'b0;
			vic_ok_q <= 1'b0;
			hit_idx_q <= '0;
			vic_idx_q <= '0;
			vic_stamp_q <= '0;
			dmask_q <= '0;
		end else if (shift) begin
			if (head.match && !hit_q) begin
				hit_q <= 1'b1;
				hit_idx_q <= pos;
			end
			if (head.dirty) dmask_q[pos] <= 1'b1;
			if (!head.pinned && (!vic_ok_q || head.stamp < vic_stamp_q)) begin
				vic_ok_q <= 1'b1;
				vic_idx_q <= pos;
				vic_stamp_q <= head.stamp;
			end
		end
		if (state_q == ST_DONE) begin
			res_q <= '0;
			unique case (op_t'(req_q.opcode))
				OP_LOOKUP: begin
					if (hit_q) begin
						res_q.hit <= 1'b1;
						res_q.result_index <= hit_idx_q;
					end else begin
						res_q.flush_mask <= dmask_q;
						res_q.full_res <= !vic_ok_q;
						res_q.fetch_needed <= vic_ok_q;
						res_q.result_index <= vic_ok_q ? vic_idx_q : 4'd0;
					end
				end
				OP_QUERY: res_q.dirty_flag <= idx_ok && dmask_q[req_q.entry_index];
				OP_WBACK: if (idx_ok && dmask_q[req_q.entry_index])
					res_q.flush_mask[req_q.entry_index] <= 1'b1;
				default: ;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_done_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_DONE) else $error("done without commit");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("busy not raised");
	a_hit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.hit && (result.full_res || result.fetch_needed)))
		else $error("hit with miss flags");
	a_flush_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.fetch_needed |-> (dbits & result.flush_mask) == '0)
		else $error("flushed entry still dirty");
`endif
endmodule
`default_nettype wire
